FILE: hw/rtl/nlog_pkg.sv
// shared types, constants and functions for the atanh-series logarithm
// no dependencies
package nlog_pkg;

  localparam int unsigned TermsDef = 4;
  localparam int unsigned TermsMax = 16;

  // status codes
  localparam logic [1:0] StFinite = 2'd0;
  localparam logic [1:0] StNan    = 2'd1;
  localparam logic [1:0] StNegInf = 2'd2;
  localparam logic [1:0] StPosInf = 2'd3;

  localparam logic [47:0] Ln2Q48 = 48'hB17217F7D1CF;

  // sideband that travels beside the arithmetic
  typedef struct packed {
    logic [1:0]        status;
    logic signed [9:0] expo;
  } side_t;

  // reciprocal 1/(2i+1) in Q1.30, floor
  function automatic logic [30:0] recip_q30(input logic [4:0] idx);
    logic [31:0] r;
    begin
      r = 32'd0;
      case (idx)
        5'd0:  r = 32'd1073741824;
        5'd1:  r = 32'd357913941;
        5'd2:  r = 32'd214748364;
        5'd3:  r = 32'd153391689;
        5'd4:  r = 32'd119304647;
        5'd5:  r = 32'd97612893;
        5'd6:  r = 32'd82595524;
        5'd7:  r = 32'd71582788;
        5'd8:  r = 32'd63161283;
        5'd9:  r = 32'd56512727;
        5'd10: r = 32'd51130563;
        5'd11: r = 32'd46684427;
        5'd12: r = 32'd42949672;
        5'd13: r = 32'd39768215;
        5'd14: r = 32'd37025580;
        5'd15: r = 32'd34636833;
        5'd16: r = 32'd32537631;
        default: r = 32'd0;
      endcase
      return r[30:0];
    end
  endfunction

endpackage

FILE: hw/rtl/nlog_div.sv
// restoring divider for z = (m-1)*2^30/(m+1), one quotient bit per stage
// depends on nlog_pkg
module nlog_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [22:0]          num_i,
  input  logic [24:0]          den_i,
  input  nlog_pkg::side_t      side_i,
  output logic                 vld_o,
  output logic [29:0]          quo_o,
  output nlog_pkg::side_t      side_o
);
  import nlog_pkg::*;

  localparam int unsigned Steps = 30;

  logic [Steps:0]   vld_q;
  logic [25:0]      rem_q  [Steps+1];
  logic [24:0]      den_q  [Steps+1];
  logic [29:0]      quo_q  [Steps+1];
  side_t            side_q [Steps+1];

  // stage 0 takes the operands
  always_comb begin
    rem_q[0]  = {3'd0, num_i};
    den_q[0]  = den_i;
    quo_q[0]  = '0;
    side_q[0] = side_i;
  end
  assign vld_q[0] = vld_i;

  // one shift-subtract per stage
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [26:0] sh;
    logic [26:0] diff;
    logic        ge;
    assign sh   = {rem_q[s], 1'b0};
    assign diff = sh - {2'd0, den_q[s]};
    assign ge   = !diff[26];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? diff[25:0] : sh[25:0];
        den_q[s+1]  <= den_q[s];
        quo_q[s+1]  <= {quo_q[s][28:0], ge};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign vld_o  = vld_q[Steps];
  assign quo_o  = quo_q[Steps];
  assign side_o = side_q[Steps];

endmodule

FILE: hw/rtl/nlog_front.sv
// input decode: special cases and subnormal normalisation
// depends on nlog_pkg
module nlog_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [31:0]      x_bits_i,
  output logic             vld_o,
  output logic [22:0]      num_o,
  output logic [24:0]      den_o,
  output nlog_pkg::side_t  side_o
);
  import nlog_pkg::*;

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic [4:0]  lz;
  logic [1:0]  st;
  logic        found;

  assign sgn = x_bits_i[31];
  assign ex  = x_bits_i[30:23];
  assign fr  = x_bits_i[22:0];

  // leading-zero count of the fraction
  always_comb begin
    lz = 5'd0;
    found = 1'b0;
    for (int b = 22; b >= 0; b--) begin
      if (fr[b] && !found) begin
        lz = 5'(22 - b);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    if (ex == 8'hFF && fr != '0)     st = StNan;
    else if (ex == 8'd0 && fr == '0) st = StNegInf;
    else if (sgn)                    st = StNan;
    else if (ex == 8'hFF)            st = StPosInf;
    else                             st = StFinite;
  end

  // stage register 1: raw fields
  logic        vld_q;
  logic [7:0]  ex_q;
  logic [22:0] fr_q;
  logic [4:0]  lz_q;
  logic [1:0]  st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q <= ex;
      fr_q <= fr;
      lz_q <= lz;
      st_q <= st;
    end
  end

  // normalise subnormals with a shift by the count
  logic [23:0]       sig;
  logic signed [9:0] e_d;
  logic [23:0]       shf;

  assign shf = {1'b0, fr_q} << (lz_q + 5'd1);
  always_comb begin
    if (ex_q == 8'd0) begin
      sig = shf;
      e_d = -10'sd127 - $signed({5'd0, lz_q});
    end else begin
      sig = {1'b1, fr_q};
      e_d = $signed({2'd0, ex_q}) - 10'sd127;
    end
  end

  // stage register 2: operands of the divider
  logic        vld2_q;
  logic [22:0] num_q;
  logic [24:0] den_q;
  side_t       side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q         <= sig[22:0];
      den_q         <= {1'b0, sig} + 25'h800000;
      side_q.status <= st_q;
      side_q.expo   <= e_d;
    end
  end

  assign vld_o  = vld2_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

FILE: hw/rtl/nlog_series.sv
// horner series in z squared and final scaling, one multiply per horner stage
// depends on nlog_pkg
module nlog_series #(
  parameter int unsigned Terms = nlog_pkg::TermsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [29:0]      z_i,
  input  nlog_pkg::side_t  side_i,
  output logic             vld_o,
  output logic [31:0]      ln_value_o,
  output logic [1:0]       status_o
);
  import nlog_pkg::*;

  // stage a: z squared
  logic        va_q;
  logic [29:0] za_q;
  logic [29:0] z2a_q;
  side_t       sa_q;
  logic [59:0] zz;
  assign zz = z_i * z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en_i) va_q <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      za_q  <= z_i;
      z2a_q <= zz[59:30];
      sa_q  <= side_i;
    end
  end

  // horner stages: each one multiply then add of the next coefficient
  logic [Terms:0] hv_q;
  logic [30:0]    hr_q  [Terms+1];
  logic [29:0]    hz_q  [Terms+1];
  logic [29:0]    hz2_q [Terms+1];
  side_t          hs_q  [Terms+1];

  assign hv_q[0] = va_q;
  always_comb begin
    hr_q[0]  = recip_q30(5'(Terms));
    hz_q[0]  = za_q;
    hz2_q[0] = z2a_q;
    hs_q[0]  = sa_q;
  end

  for (genvar k = 0; k < Terms; k++) begin : g_horner
    logic [60:0] prod;
    assign prod = hz2_q[k] * hr_q[k];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) hv_q[k+1] <= 1'b0;
      else if (en_i) hv_q[k+1] <= hv_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hr_q[k+1]  <= recip_q30(5'(Terms - 1 - k)) + prod[60:30];
        hz_q[k+1]  <= hz_q[k];
        hz2_q[k+1] <= hz2_q[k];
        hs_q[k+1]  <= hs_q[k];
      end
    end
  end

  // stage b: ln(m) = z*r/2^11 and e*ln2
  logic               vb_q;
  logic [49:0]        lnm_q;
  logic signed [57:0] eln_q;
  side_t              sb_q;
  logic [60:0]        zr;
  assign zr = hz_q[Terms] * hr_q[Terms];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en_i) vb_q <= hv_q[Terms];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lnm_q <= zr[60:11];
      eln_q <= hs_q[Terms].expo * $signed({1'b0, Ln2Q48});
      sb_q  <= hs_q[Terms];
    end
  end

  // stage c: sum and floor to Q8.24
  logic               vc_q;
  logic [31:0]        lv_q;
  logic [1:0]         st_q;
  logic signed [58:0] sum;
  assign sum = 59'(eln_q) + $signed({9'd0, lnm_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en_i) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lv_q <= (sb_q.status == StFinite) ? sum[55:24] : 32'd0;
      st_q <= sb_q.status;
    end
  end

  assign vld_o      = vc_q;
  assign ln_value_o = lv_q;
  assign status_o   = st_q;

endmodule

FILE: hw/rtl/natural_log_atanh_series.sv
// natural log of a single-precision word via an atanh series, Q8.24 result
// pipeline stages in order: decode, divider bits, square, horner, two tail stages
// throughput: one request per cycle; the whole pipe advances when the output is free
// stalls hold every stage, nothing is lost or repeated
// reset (async, active low) clears only the valid bits
// depends on nlog_pkg, nlog_front, nlog_div, nlog_series
module natural_log_atanh_series #(
  parameter int unsigned Terms = nlog_pkg::TermsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] ln_value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import nlog_pkg::*;

  logic        en;
  logic        fv, dv, sv;
  logic [22:0] num;
  logic [24:0] den;
  side_t       fs, ds;
  logic [29:0] z;

  // pipe moves when the last stage is empty or taken
  assign en            = !sv || m_axis_tready;
  assign s_axis_tready = en;

  nlog_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid && en),
    .x_bits_i(s_axis_tdata), .vld_o(fv), .num_o(num), .den_o(den), .side_o(fs)
  );

  nlog_div u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(fv), .num_i(num), .den_i(den),
    .side_i(fs), .vld_o(dv), .quo_o(z), .side_o(ds)
  );

  nlog_series #(.Terms(Terms)) u_series (
    .clk_i, .rst_ni, .en_i(en), .vld_i(dv), .z_i(z), .side_i(ds),
    .vld_o(sv), .ln_value_o(m_axis_tdata), .status_o(m_axis_tuser)
  );

  assign m_axis_tvalid = sv;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // non-finite status carries zero value
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != StFinite |-> m_axis_tdata == 32'd0)
    else $error("non-finite result not zero");
  // ready only withdrawn while a result waits
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without cause");

endmodule

FILE: verif/tb.sv
// testbench for natural_log_atanh_series: drives random and directed float words,
// predicts ln(x) in Q8.24 with a status code and checks each result in order
// depends on nlog_pkg and the natural_log_atanh_series rtl
`timescale 1ns / 1ps

class ln_scoreboard;
  logic [31:0] want_value[$];
  logic [1:0]  want_status[$];
  int          n_fail;

  function new();
    n_fail = 0;
  endfunction

  // bit-exact atanh-series logarithm
  function void note_word(logic [31:0] w);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [63:0] sig, num, den, z, z2, r, lnm, mag;
    longint      e, sum, q;
    begin
      sgn = w[31];
      ex  = w[30:23];
      fr  = w[22:0];
      if (ex == 8'hFF && fr != 0) begin
        push(32'd0, nlog_pkg::StNan);
      end else if (ex == 0 && fr == 0) begin
        push(32'd0, nlog_pkg::StNegInf);
      end else if (sgn) begin
        push(32'd0, nlog_pkg::StNan);
      end else if (ex == 8'hFF) begin
        push(32'd0, nlog_pkg::StPosInf);
      end else begin
        if (ex == 0) begin
          sig = {41'd0, fr};
          e   = -126;
          while (sig[23] == 1'b0) begin
            sig = sig << 1;
            e   = e - 1;
          end
        end else begin
          sig = {40'd0, 1'b1, fr};
          e   = longint'(ex) - 127;
        end
        num = sig - 64'h800000;
        den = sig + 64'h800000;
        z   = (num << 30) / den;
        z2  = (z * z) >> 30;
        r   = (64'd1 << 30) / (2 * nlog_pkg::TermsDef + 1);
        for (int i = int'(nlog_pkg::TermsDef) - 1; i >= 0; i--)
          r = (64'd1 << 30) / (2 * i + 1) + ((z2 * r) >> 30);
        lnm = (z * r) >> 11;
        sum = e * longint'({16'd0, nlog_pkg::Ln2Q48}) + longint'(lnm);
        if (sum >= 0) begin
          q = longint'(sum >>> 24);
        end else begin
          mag = 64'(-sum);
          q   = -longint'((mag + 64'hFFFFFF) >> 24);
        end
        push(q[31:0], nlog_pkg::StFinite);
      end
    end
  endfunction

  function void push(logic [31:0] v, logic [1:0] s);
    want_value.push_back(v);
    want_status.push_back(s);
  endfunction

  function void check_result(logic [31:0] v, logic [1:0] s);
    logic [31:0] ev;
    logic [1:0]  es;
    begin
      if (want_value.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result value %h status %0d", v, s);
      end else begin
        ev = want_value.pop_front();
        es = want_status.pop_front();
        if (ev !== v || es !== s) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: expected %h/%0d got %h/%0d", ev, es, v, s);
        end
      end
    end
  endfunction

  function int pending();
    return want_value.size();
  endfunction
endclass

module tb;
  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  ln_scoreboard sb;
  longint       cycles;
  bit           calm;
  int           n_rand;

  natural_log_atanh_series dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // send one request, idling at random before it
  task automatic send_word(logic [31:0] w);
    while (!calm && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(w);
  endtask

  function automatic logic [31:0] rand_word();
    logic [7:0] ex;
    begin
      case ($urandom_range(9))
        0: ex = 8'h00;
        1: ex = 8'hFF;
        2, 3: ex = 8'(8'd127 + $urandom_range(2) - 1);
        default: ex = 8'($urandom_range(255));
      endcase
      rand_word = {($urandom_range(7) == 0), ex, 23'($urandom)};
      if ($urandom_range(15) == 0) rand_word[22:0] = 23'd1 << $urandom_range(22);
    end
  endfunction

  initial begin
    sb            = new();
    cycles        = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 32'd0;
    m_axis_tready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zeros, infinities, nan, negatives, subnormals, one, extremes
    begin
      logic [31:0] dir[20];
      dir = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'hBF80_0000,
              32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h3F80_0000,
              32'h3FFF_FFFF, 32'h3F80_0001, 32'h4000_0000, 32'h402D_F854,
              32'h7F7F_FFFF, 32'h0080_0000, 32'h3F7F_FFFF, 32'h5555_5555};
      foreach (dir[i]) send_word(dir[i]);
    end

    // pause until the pipe has drained
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);

    for (n_rand = 0; n_rand < 1700; n_rand++) begin
      calm = (n_rand >= 600 && n_rand < 800);
      send_word(rand_word());
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (sb.n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/nlog_pkg.sv
hw/rtl/nlog_div.sv
hw/rtl/nlog_front.sv
hw/rtl/nlog_series.sv
hw/rtl/natural_log_atanh_series.sv
verif/tb.sv
